// ===== src/kma_pkg.sv =====
// shared types, sizes and codes for the keyed mean accumulator
// no dependencies; imported by every module of the block but kma_ram
`timescale 1ns / 1ps

package kma_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);

  // field widths
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int SUM_W      = 48;
  localparam int COUNT_W    = 16;
  localparam int OUT_IDX_W  = 6;
  localparam int STATUS_W   = 2;

  // stream word widths
  localparam int S_DATA_W = 72;  // key, value, read index, zero pad
  localparam int M_DATA_W = 88;  // index, key, count, mean, zero pad
  localparam int M_USER_W = 3;   // status, new entry flag

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // divider steps, one quotient bit each
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // command codes
  localparam logic CMD_ACC  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  // one table entry as stored in memory
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_UPDATE,
    S_APPEND,
    S_RD_ADDR,
    S_RD_DATA,
    S_DIVIDE,
    S_DONE
  } state_t;

endpackage

// ===== src/keyed_mean_accumulator_unit.sv =====
// top level of the keyed mean accumulator: sequencer, entry table and divider
// depends on kma_pkg, kma_ram, kma_div
`timescale 1ns / 1ps

// Group-by-key averaging table with stream channels.
// Input word: s_tuser is the command (0 accumulate, 1 read); s_tdata carries
// sample key, sample value and read index. Output word: m_tuser carries status
// and the new entry flag; m_tdata carries index, key, count and mean.
// One word is worked on at a time; s_tready is high only while idle.
// Accumulate: the filled entries are scanned in order through one ram read
// port, one entry a cycle; a hit updates the entry unless its count is
// saturated, a miss appends a new entry (at once into an empty table), and a
// miss on a full table reports the full status.
// Read: one ram access plus a 48-step shift-subtract divider; a read beyond
// the filled entries reports empty without the ram data or divider steps.
// s_tready returns at the edge that loads the output word, so each word holds
// the block until its result is loaded into the output register.
// The result sits in an output register until m_tready takes it; the next
// input word may be accepted while it waits, and a second result waits in the
// sequencer until the output register frees up.
// Reset empties the table at once (fill count to zero) and drops any pending
// output word; the ram contents are not cleared and need no sweep.
module keyed_mean_accumulator_unit
  import kma_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // sample_key, sample_value, read_index, pad
  input  logic                s_tuser,   // cmd
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // entry_index, entry_key, entry_count,
                                         // entry_mean, pad
  output logic [M_USER_W-1:0] m_tuser    // status, new_entry
);

  state_t state, state_next;

  // latched input word
  logic [KEY_W-1:0]         key_r;
  logic [VAL_W-1:0]         val_r;
  logic [OUT_IDX_W-1:0]     ridx_r;

  logic [FILL_W-1:0]        filled;
  logic [FILL_W-1:0]        ptr;
  logic                     cmp_vld;
  logic [FILL_W-1:0]        cmp_idx;

  // pending hit update
  logic [IDX_W-1:0]         hit_idx;
  logic [SUM_W-1:0]         upd_sum;
  logic [COUNT_W-1:0]       upd_count;

  // result being built
  logic [STATUS_W-1:0]      res_status;
  logic [OUT_IDX_W-1:0]     res_index;
  logic [KEY_W-1:0]         res_key;
  logic [COUNT_W-1:0]       res_count;
  logic [VAL_W-1:0]         res_mean;
  logic                     res_new;

  // ram and divider hookup
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  entry_t                   ram_wdata;
  logic [IDX_W-1:0]         ram_raddr;
  logic [ENTRY_W-1:0]       ram_rdata;
  entry_t                   rd_entry;
  logic                     div_start;
  logic                     div_done;
  logic signed [VAL_W-1:0]  div_q;

  logic                     in_acc;
  logic                     out_free;
  logic                     cmp_hit;
  logic                     cmp_last;
  logic                     rd_empty;
  logic [SUM_W-1:0]         val_ext;
  logic [KEY_W-1:0]         in_key;
  logic [VAL_W-1:0]         in_val;
  logic [OUT_IDX_W-1:0]     in_ridx;

  assign in_key  = s_tdata[KEY_W-1:0];
  assign in_val  = s_tdata[KEY_W+VAL_W-1:KEY_W];
  assign in_ridx = s_tdata[KEY_W+VAL_W+OUT_IDX_W-1:KEY_W+VAL_W];

  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign rd_entry = entry_t'(ram_rdata);
  assign val_ext  = {{(SUM_W - VAL_W){val_r[VAL_W-1]}}, val_r};

  // search compare on the entry read last cycle
  assign cmp_hit  = cmp_vld && (rd_entry.key == key_r);
  assign cmp_last = cmp_vld && (cmp_idx == filled - FILL_W'(1));
  assign rd_empty = 32'(ridx_r) >= 32'(filled);

  kma_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kma_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd_entry.sum),
    .divisor  (rd_entry.count),
    .done     (div_done),
    .quotient (div_q)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (s_tuser == CMD_READ) begin
            state_next = S_RD_ADDR;
          end else if (filled == '0) begin
            state_next = S_APPEND;
          end else begin
            state_next = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (cmp_hit) begin
          state_next = (rd_entry.count == COUNT_MAX) ? S_DONE : S_UPDATE;
        end else if (cmp_last) begin
          state_next = (filled == FILL_W'(TABLE_DEPTH)) ? S_DONE : S_APPEND;
        end
      end
      S_UPDATE:  state_next = S_DONE;
      S_APPEND:  state_next = S_DONE;
      S_RD_ADDR: state_next = rd_empty ? S_DONE : S_RD_DATA;
      S_RD_DATA: state_next = S_DIVIDE;
      S_DIVIDE:  state_next = div_done ? S_DONE : S_DIVIDE;
      S_DONE:    state_next = out_free ? S_IDLE : S_DONE;
      default:   state_next = S_IDLE;
    endcase
  end

  // ram and divider controls
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hit_idx;
    ram_wdata = '{key: key_r, sum: upd_sum, count: upd_count};
    ram_raddr = ptr[IDX_W-1:0];
    div_start = 1'b0;
    unique case (state)
      S_UPDATE: begin
        ram_we = 1'b1;
      end
      S_APPEND: begin
        ram_we    = 1'b1;
        ram_waddr = filled[IDX_W-1:0];
        ram_wdata = '{key: key_r, sum: val_ext, count: COUNT_W'(1)};
      end
      S_RD_ADDR: begin
        ram_raddr = IDX_W'(ridx_r);
      end
      S_RD_DATA: begin
        div_start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      filled   <= '0;
      cmp_vld  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      cmp_vld <= (state == S_SEARCH) && !cmp_hit && !cmp_last;
      if (state == S_APPEND) begin
        filled <= filled + FILL_W'(1);
      end
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          key_r  <= in_key;
          val_r  <= in_val;
          ridx_r <= in_ridx;
          ptr    <= '0;
        end
      end
      S_SEARCH: begin
        ptr     <= ptr + FILL_W'(1);
        cmp_idx <= ptr;
        if (cmp_hit) begin
          hit_idx    <= cmp_idx[IDX_W-1:0];
          upd_sum    <= rd_entry.sum + val_ext;
          upd_count  <= rd_entry.count + COUNT_W'(1);
          res_status <= ST_SATURATED;
          res_index  <= OUT_IDX_W'(cmp_idx);
          res_key    <= key_r;
          res_count  <= rd_entry.count;
          res_mean   <= '0;
          res_new    <= 1'b0;
        end else if (cmp_last) begin
          res_status <= ST_FULL;
          res_index  <= '0;
          res_key    <= key_r;
          res_count  <= '0;
          res_mean   <= '0;
          res_new    <= 1'b0;
        end
      end
      S_UPDATE: begin
        res_status <= ST_OK;
        res_count  <= upd_count;
      end
      S_APPEND: begin
        res_status <= ST_OK;
        res_index  <= OUT_IDX_W'(filled);
        res_key    <= key_r;
        res_count  <= COUNT_W'(1);
        res_mean   <= '0;
        res_new    <= 1'b1;
      end
      S_RD_ADDR: begin
        res_status <= ST_EMPTY;
        res_index  <= ridx_r;
        res_key    <= '0;
        res_count  <= '0;
        res_mean   <= '0;
        res_new    <= 1'b0;
      end
      S_RD_DATA: begin
        res_status <= ST_OK;
        res_key    <= rd_entry.key;
        res_count  <= rd_entry.count;
      end
      S_DIVIDE: begin
        if (div_done) begin
          res_mean <= div_q;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tdata <= {{(M_DATA_W - OUT_IDX_W - KEY_W - COUNT_W - VAL_W){1'b0}},
                  res_mean, res_count, res_key, res_index};
      m_tuser <= {res_new, res_status};
    end
  end

endmodule

// ===== src/kma_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module kma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/kma_div.sv =====
// iterative signed divider: 48-bit sum by unsigned 16-bit count, one bit a cycle
// depends on kma_pkg
`timescale 1ns / 1ps

module kma_div
  import kma_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [SUM_W-1:0]   dividend,
  input  logic [COUNT_W-1:0]        divisor,
  output logic                      done,
  output logic signed [VAL_W-1:0]   quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] step;
  logic                 neg;
  logic [SUM_W-1:0]     quo;
  logic [COUNT_W-1:0]   rem;
  logic [COUNT_W-1:0]   dvs;
  logic [COUNT_W:0]     rem_sh;
  logic                 fits;
  logic [SUM_W-1:0]     q_signed;

  // restoring step on the magnitude
  assign rem_sh = {rem, quo[SUM_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + DIV_CNT_W'(1);
        if (step == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_W-1];
      quo <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[SUM_W-2:0], fits};
      rem <= fits ? COUNT_W'(rem_sh - {1'b0, dvs}) : rem_sh[COUNT_W-1:0];
    end
  end

  // truncation toward zero: negate the magnitude quotient
  assign q_signed = neg ? SUM_W'(-quo) : quo;
  assign quotient = q_signed[VAL_W-1:0];

endmodule

// ===== dv/tb_keyed_mean_accumulator_unit.sv =====
// self-checking testbench for keyed_mean_accumulator_unit: a directed table and
// random words, checked against typed expectations or an in-bench averaging predictor
// depends on kma_pkg and keyed_mean_accumulator_unit
`timescale 1ns / 1ps

module tb_keyed_mean_accumulator_unit;
  import kma_pkg::*;

  localparam int  RUN_LIMIT   = 3_000_000;
  localparam int  RAND_WORDS  = 1132;
  localparam int  POOL_SIZE   = 96;
  localparam int  HOLD_CYCLES = 400;
  localparam int  DRAIN_WAIT  = 100;
  localparam int  MAX_REPORTS = 30;

  // one output word, split into its fields
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [OUT_IDX_W-1:0] idx;
    logic [KEY_W-1:0]     key;
    logic [COUNT_W-1:0]   count;
    logic [VAL_W-1:0]     mean;
    logic                 new_entry;
  } bin_result_t;

  // one row of the directed part
  typedef struct {
    logic               cmd;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   val;
    logic [5:0]         idx;
    bit                 typed;
    bin_result_t        want;
  } probe_row_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic                s_tuser  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [M_USER_W-1:0] m_tuser;

  keyed_mean_accumulator_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the averaging bins
  logic [KEY_W-1:0]        bin_key   [TABLE_DEPTH];
  logic signed [SUM_W-1:0] bin_sum   [TABLE_DEPTH];
  logic [COUNT_W-1:0]      bin_count [TABLE_DEPTH];
  int                      bins_used = 0;

  bin_result_t pending_results [$];
  int          mismatches    = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_req      = 1'b0;
  logic        hold_done     = 1'b0;
  int          hold_left     = 0;
  int          cycle_count   = 0;

  // group-by-key mean: expected word for one accepted input word
  function automatic bin_result_t predict_bin_result(logic cmd, logic [KEY_W-1:0] key,
                                                     logic [VAL_W-1:0] val, logic [5:0] idx);
    bin_result_t r;
    int          hit;
    int          i;
    longint      quot;
    r   = '0;
    hit = -1;
    if (cmd == CMD_ACC) begin
      for (i = 0; i < bins_used; i++)
        if (hit < 0 && bin_key[i] == key) hit = i;
      r.key = key;
      if (hit >= 0) begin
        r.idx = hit[OUT_IDX_W-1:0];
        if (bin_count[hit] == COUNT_MAX) begin
          r.status = ST_SATURATED;
        end else begin
          bin_sum[hit]   = bin_sum[hit] + {{(SUM_W-VAL_W){val[VAL_W-1]}}, val};
          bin_count[hit] = bin_count[hit] + 1'b1;
          r.status       = ST_OK;
        end
        r.count = bin_count[hit];
      end else if (bins_used >= TABLE_DEPTH) begin
        // miss with every bin taken: sample dropped
        r.status = ST_FULL;
      end else begin
        bin_key[bins_used]   = key;
        bin_sum[bins_used]   = {{(SUM_W-VAL_W){val[VAL_W-1]}}, val};
        bin_count[bins_used] = COUNT_W'(1);
        r.status    = ST_OK;
        r.idx       = bins_used[OUT_IDX_W-1:0];
        r.count     = COUNT_W'(1);
        r.new_entry = 1'b1;
        bins_used++;
      end
    end else begin
      r.idx = idx;
      if (idx >= bins_used) begin
        r.status = ST_EMPTY;
      end else begin
        // signed division truncates toward zero
        quot     = longint'(bin_sum[idx]) / longint'(bin_count[idx]);
        r.status = ST_OK;
        r.key    = bin_key[idx];
        r.count  = bin_count[idx];
        r.mean   = quot[VAL_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic probe_row_t probe(logic cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val,
                                       logic [5:0] idx, bit typed, logic [STATUS_W-1:0] st,
                                       logic [OUT_IDX_W-1:0] eidx, logic [KEY_W-1:0] ekey,
                                       logic [COUNT_W-1:0] ecount, logic enew);
    probe_row_t p;
    p.cmd  = cmd;
    p.key  = key;
    p.val  = val;
    p.idx  = idx;
    p.typed = typed;
    p.want = '{status: st, idx: eidx, key: ekey, count: ecount, mean: '0, new_entry: enew};
    return p;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
    end
  endfunction

  // offer one word, wait for acceptance, queue its expected result
  task automatic send_word(input logic cmd, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] val, input logic [5:0] idx,
                           input bit typed, input bin_result_t want);
    bin_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {2'b00, idx, val, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = predict_bin_result(cmd, key, val, idx);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // receiver readiness, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready  <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each output word with the oldest expectation
  bin_result_t want_word;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t ns: unexpected word, expected none actual %h/%h",
                   $time, m_tuser, m_tdata);
      end else begin
        want_word = pending_results.pop_front();
        check_field("status", 32'(want_word.status), 32'(m_tuser[1:0]));
        check_field("new_entry", 32'(want_word.new_entry), 32'(m_tuser[2]));
        check_field("entry_index", 32'(want_word.idx), 32'(m_tdata[5:0]));
        check_field("entry_key", want_word.key, m_tdata[37:6]);
        check_field("entry_count", 32'(want_word.count), 32'(m_tdata[53:38]));
        check_field("entry_mean", want_word.mean, m_tdata[85:54]);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("keyed_mean_accumulator_unit: mismatch");
      $finish;
    end
  end

  // stimulus
  probe_row_t       probe_rows [18];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  initial begin
    int          n;
    int          pick;
    logic        cmd;
    logic [31:0] key;

    // extremes, empty reads, first bins, truncation toward zero
    probe_rows[0]  = probe(CMD_READ, 32'h0, 32'h0, 6'd0, 1, ST_EMPTY, 6'd0, 32'h0, 16'd0, 0);
    probe_rows[1]  = probe(CMD_READ, 32'hFFFFFFFF, 32'hFFFFFFFF, 6'd63, 1,
                           ST_EMPTY, 6'd63, 32'h0, 16'd0, 0);
    probe_rows[2]  = probe(CMD_ACC, 32'h0, 32'h7FFFFFFF, 6'd0, 1, ST_OK, 6'd0, 32'h0, 16'd1, 1);
    probe_rows[3]  = probe(CMD_ACC, 32'h0, 32'h80000000, 6'd63, 1, ST_OK, 6'd0, 32'h0, 16'd2, 0);
    probe_rows[4]  = probe(CMD_READ, 32'h0, 32'h0, 6'd0, 0, ST_OK, 6'd0, 32'h0, 16'd0, 0);
    probe_rows[5]  = probe(CMD_READ, 32'h0, 32'h0, 6'd1, 1, ST_EMPTY, 6'd1, 32'h0, 16'd0, 0);
    probe_rows[6]  = probe(CMD_ACC, 32'hFFFFFFFF, 32'h80000000, 6'd0, 1,
                           ST_OK, 6'd1, 32'hFFFFFFFF, 16'd1, 1);
    probe_rows[7]  = probe(CMD_ACC, 32'hFFFFFFFF, 32'h80000000, 6'd0, 1,
                           ST_OK, 6'd1, 32'hFFFFFFFF, 16'd2, 0);
    probe_rows[8]  = probe(CMD_READ, 32'h0, 32'h0, 6'd1, 0, ST_OK, 6'd0, 32'h0, 16'd0, 0);
    probe_rows[9]  = probe(CMD_ACC, 32'h1, 32'hFFFFFFFF, 6'd0, 1, ST_OK, 6'd2, 32'h1, 16'd1, 1);
    probe_rows[10] = probe(CMD_ACC, 32'h80000000, 32'h1, 6'd0, 1,
                           ST_OK, 6'd3, 32'h80000000, 16'd1, 1);
    probe_rows[11] = probe(CMD_READ, 32'h0, 32'h0, 6'd2, 0, ST_OK, 6'd0, 32'h0, 16'd0, 0);
    probe_rows[12] = probe(CMD_ACC, 32'h1, 32'h00010000, 6'd0, 0, ST_OK, 6'd0, 32'h0, 16'd0, 0);
    probe_rows[13] = probe(CMD_ACC, 32'h1, 32'h00020000, 6'd0, 0, ST_OK, 6'd0, 32'h0, 16'd0, 0);
    probe_rows[14] = probe(CMD_READ, 32'h0, 32'h0, 6'd2, 0, ST_OK, 6'd0, 32'h0, 16'd0, 0);
    probe_rows[15] = probe(CMD_READ, 32'h0, 32'h0, 6'd4, 1, ST_EMPTY, 6'd4, 32'h0, 16'd0, 0);
    probe_rows[16] = probe(CMD_ACC, 32'h80000000, 32'hFFFF8000, 6'd0, 0,
                           ST_OK, 6'd0, 32'h0, 16'd0, 0);
    probe_rows[17] = probe(CMD_READ, 32'h0, 32'h0, 6'd3, 0, ST_OK, 6'd0, 32'h0, 16'd0, 0);

    // key pool: more distinct keys than bins so the table runs full
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFFFFFF;
    for (n = 2; n < POOL_SIZE; n++) key_pool[n] = $urandom();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 23;
    recv_idle_pct = 47;
    foreach (probe_rows[i])
      send_word(probe_rows[i].cmd, probe_rows[i].key, probe_rows[i].val, probe_rows[i].idx,
                probe_rows[i].typed, probe_rows[i].want);

    // random words in three idling phases
    for (n = 0; n < RAND_WORDS; n++) begin
      if (n == 0) begin
        send_idle_pct = 23;
        recv_idle_pct = 47;
      end else if (n == RAND_WORDS / 3) begin
        send_idle_pct = 47;
        recv_idle_pct = 23;
      end else if (n == 2 * RAND_WORDS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (n == 60) hold_req <= 1'b1;
      pick = $urandom_range(99);
      cmd  = (pick < 30) ? CMD_READ : CMD_ACC;
      key  = (pick < 86) ? key_pool[$urandom_range(POOL_SIZE - 1)] : $urandom();
      send_word(cmd, key, $urandom(), 6'($urandom_range(63)), 0, '0);
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("keyed_mean_accumulator_unit: match");
    else
      $display("keyed_mean_accumulator_unit: mismatch");
    $finish;
  end

endmodule
